### rtl/cpbd_pkg.sv
// ============================================================================
// cpbd_pkg: shared constants for the chained pulse bit decoder stepper
// Phase codes, event op codes, register indexes, field widths and register reset values.
// ============================================================================
package cpbd_pkg;

    localparam int PHASE_W     = 3;
    localparam int TICK_W      = 5;
    localparam int START_W     = 4;
    localparam int STEP_W      = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BIT   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FWD   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ABORT = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_MIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_COUNT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_GAP      = 2'd3;

    localparam logic [START_W-1:0] START_MIN_RST     = 4'd3;
    localparam logic [TICK_W-1:0]  FRAME_TIMEOUT_RST = 5'd15;
    localparam logic [STEP_W-1:0]  STEP_COUNT_RST    = 8'd13;
    localparam logic [STEP_W-1:0]  STEP_GAP_RST      = 8'd8;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

### rtl/cpbd_evt_if.sv
// ============================================================================
// cpbd_evt_if: event channel
// Valid/ready channel carrying one line edge or timer tick event.
// ============================================================================
interface cpbd_evt_if;

    logic valid;
    logic ready;
    logic op;
    logic line_level;

    modport source (output valid, output op, output line_level, input ready);
    modport sink   (input valid, input op, input line_level, output ready);

endinterface

### rtl/cpbd_res_if.sv
// ============================================================================
// cpbd_res_if: result channel
// Valid/ready channel carrying the line drive, decoded bit and motor state.
// ============================================================================
interface cpbd_res_if;

    logic                          valid;
    logic                          ready;
    logic                          out_level;
    logic                          bit_value;
    logic                          motor_enable;
    logic                          motor_dir;
    logic                          step_pulse;
    logic [cpbd_pkg::PHASE_W-1:0]  phase;

    modport source (
        output valid, output out_level, output bit_value, output motor_enable,
        output motor_dir, output step_pulse, output phase, input ready
    );
    modport sink (
        input valid, input out_level, input bit_value, input motor_enable,
        input motor_dir, input step_pulse, input phase, output ready
    );

endinterface

### rtl/chained_pulse_bit_decoder_stepper.sv
// ============================================================================
// chained_pulse_bit_decoder_stepper: daisy-chain pulse-width node with stepper
// Decodes this node's bit from a pulse-width frame, forwards the rest of the
// frame downstream and runs a stepper move when the decoded bit changes.
// ============================================================================
// Latency: the result of an event is valid in the cycle after its transfer.
// Throughput: one event per cycle while the result side can take the
// previous result; the state registers and the result register are updated
// together in the cycle of the transfer. The result register acts as the
// output stage: a new event is taken while the previous result is being
// transferred out in the same cycle. Reset (rst_n low, asynchronous): phase
// idle, all frame and motor state zero, registers back to their default values, no result pending.
module chained_pulse_bit_decoder_stepper (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cpbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cpbd_pkg::CFG_DATA_W-1:0]    cfg_data,
    cpbd_evt_if.sink                           evt,
    cpbd_res_if.source                         res
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cpbd_pkg::START_W-1:0] start_min_reg;
    logic [cpbd_pkg::TICK_W-1:0]  frame_timeout_reg;
    logic [cpbd_pkg::STEP_W-1:0]  step_count_reg;
    logic [cpbd_pkg::STEP_W-1:0]  step_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg     <= cpbd_pkg::START_MIN_RST;
            frame_timeout_reg <= cpbd_pkg::FRAME_TIMEOUT_RST;
            step_count_reg    <= cpbd_pkg::STEP_COUNT_RST;
            step_gap_reg      <= cpbd_pkg::STEP_GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cpbd_pkg::CFG_START_MIN:
                    start_min_reg <= cfg_data[cpbd_pkg::START_W-1:0];
                cpbd_pkg::CFG_FRAME_TIMEOUT:
                    frame_timeout_reg <= cfg_data[cpbd_pkg::TICK_W-1:0];
                cpbd_pkg::CFG_STEP_COUNT:
                    step_count_reg <= cfg_data;
                cpbd_pkg::CFG_STEP_GAP:
                    step_gap_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame and motor state
    // ------------------------------------------------------------------
    logic [cpbd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [cpbd_pkg::TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic                         timer_on_reg, timer_on_next;
    logic                         own_bit_reg, own_bit_next;
    logic                         applied_bit_reg, applied_bit_next;
    logic                         out_level_reg, out_level_next;
    logic [cpbd_pkg::STEP_W-1:0]  steps_left_reg, steps_left_next;
    logic [cpbd_pkg::STEP_W-1:0]  gap_left_reg, gap_left_next;
    logic                         step_high_reg, step_high_next;
    logic                         motor_dir_reg, motor_dir_next;

    // Result register (output stage)
    logic                         res_valid_reg;
    logic                         res_enable_reg;

    logic                         take;
    logic [cpbd_pkg::TICK_W:0]    tick_inc;
    logic                         move_run;

    // A new event enters whenever the output stage is empty or drains now.
    assign evt.ready = !res_valid_reg || res.ready;
    assign take      = evt.valid && evt.ready;

    assign tick_inc = {1'b0, tick_count_reg} + {{cpbd_pkg::TICK_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        timer_on_next    = timer_on_reg;
        own_bit_next     = own_bit_reg;
        applied_bit_next = applied_bit_reg;
        out_level_next   = out_level_reg;
        steps_left_next  = steps_left_reg;
        gap_left_next    = gap_left_reg;
        step_high_next   = step_high_reg;
        motor_dir_next   = motor_dir_reg;

        if (evt.op == cpbd_pkg::OP_EDGE)
        begin
            case (phase_reg)
                cpbd_pkg::PH_IDLE:
                begin
                    // falling edge opens a frame
                    if (!evt.line_level)
                    begin
                        tick_count_next = '0;
                        timer_on_next   = 1'b1;
                        phase_next      = cpbd_pkg::PH_START;
                    end
                end
                cpbd_pkg::PH_START:
                begin
                    if (tick_count_reg > {1'b0, start_min_reg})
                    begin
                        tick_count_next = '0;
                        out_level_next  = 1'b0;
                        phase_next      = cpbd_pkg::PH_BIT;
                    end
                    else
                    begin
                        phase_next = cpbd_pkg::PH_ABORT;
                    end
                end
                cpbd_pkg::PH_BIT:
                begin
                    // one tick of high width means 0, anything else 1
                    own_bit_next = (tick_count_reg != cpbd_pkg::TICK_W'(1));
                    phase_next   = cpbd_pkg::PH_FWD;
                end
                cpbd_pkg::PH_FWD:
                begin
                    out_level_next  = evt.line_level;
                    tick_count_next = '0;
                end
                cpbd_pkg::PH_ABORT:
                begin
                    timer_on_next  = 1'b0;
                    out_level_next = 1'b1;
                    phase_next     = cpbd_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = cpbd_pkg::PH_IDLE;
                end
            endcase
        end
        else
        begin
            // frame timeout counter
            if (timer_on_reg)
            begin
                if (tick_inc > {1'b0, frame_timeout_reg})
                begin
                    phase_next      = cpbd_pkg::PH_IDLE;
                    tick_count_next = '0;
                    timer_on_next   = 1'b0;
                    out_level_next  = 1'b1;
                end
                else
                begin
                    tick_count_next = tick_inc[cpbd_pkg::TICK_W-1:0];
                end
            end

            // stepper: pulse end loads the gap, gap end starts the next pulse
            if (step_high_reg)
            begin
                step_high_next  = 1'b0;
                steps_left_next = steps_left_reg - cpbd_pkg::STEP_W'(1);
                gap_left_next   = step_gap_reg;
                if (step_gap_reg == '0)
                begin
                    if (steps_left_next != '0)
                        step_high_next = 1'b1;
                    else
                        applied_bit_next = own_bit_reg;
                end
            end
            else if (gap_left_reg != '0)
            begin
                gap_left_next = gap_left_reg - cpbd_pkg::STEP_W'(1);
                if (gap_left_next == '0)
                begin
                    if (steps_left_reg != '0)
                        step_high_next = 1'b1;
                    else
                        applied_bit_next = own_bit_reg;
                end
            end
        end

        // move start, judged on the updated state
        if (!step_high_next && gap_left_next == '0 &&
            phase_next == cpbd_pkg::PH_IDLE && own_bit_next != applied_bit_next)
        begin
            motor_dir_next  = !own_bit_next;
            steps_left_next = step_count_reg;
            if (step_count_reg != '0)
                step_high_next = 1'b1;
            else
                applied_bit_next = own_bit_next;
        end
    end

    assign move_run = step_high_next || (gap_left_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= cpbd_pkg::PH_IDLE;
            tick_count_reg  <= '0;
            timer_on_reg    <= 1'b0;
            own_bit_reg     <= 1'b0;
            applied_bit_reg <= 1'b0;
            out_level_reg   <= 1'b0;
            steps_left_reg  <= '0;
            gap_left_reg    <= '0;
            step_high_reg   <= 1'b0;
            motor_dir_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg       <= phase_next;
                tick_count_reg  <= tick_count_next;
                timer_on_reg    <= timer_on_next;
                own_bit_reg     <= own_bit_next;
                applied_bit_reg <= applied_bit_next;
                out_level_reg   <= out_level_next;
                steps_left_reg  <= steps_left_next;
                gap_left_reg    <= gap_left_next;
                step_high_reg   <= step_high_next;
                motor_dir_reg   <= motor_dir_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Only the enable is not a copy of a state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_enable_reg <= 1'b0;
        else if (take)
            res_enable_reg <= move_run;
    end

    // ------------------------------------------------------------------
    // Result channel: state registers double as the result payload
    // ------------------------------------------------------------------
    assign res.valid        = res_valid_reg;
    assign res.out_level    = out_level_reg;
    assign res.bit_value    = own_bit_reg;
    assign res.motor_enable = res_enable_reg;
    assign res.motor_dir    = motor_dir_reg;
    assign res.step_pulse   = step_high_reg;
    assign res.phase        = phase_reg;

endmodule

### tb/cpbd_result_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cpbd_result_checker: result predictor and comparator for the pulse node
// Watches the event, result and register write ports, keeps its own copy of
// the frame decoder and stepper state, and compares every result transfer
// against the oldest predicted node view.
// ============================================================================
module cpbd_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cpbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    cpbd_evt_if                              evt,
    cpbd_res_if                              res,
    output int                               mismatches,
    output int                               outstanding
);

    typedef struct packed {
        logic                         out_level;
        logic                         bit_value;
        logic                         motor_enable;
        logic                         motor_dir;
        logic                         step_pulse;
        logic [cpbd_pkg::PHASE_W-1:0] phase;
    } node_view_t;

    // register copies
    logic [cpbd_pkg::START_W-1:0] start_min;
    logic [cpbd_pkg::TICK_W-1:0]  frame_timeout;
    logic [cpbd_pkg::STEP_W-1:0]  step_count;
    logic [cpbd_pkg::STEP_W-1:0]  step_gap;

    // frame and stepper state
    logic [cpbd_pkg::PHASE_W-1:0] phase_q;
    logic [cpbd_pkg::TICK_W-1:0]  ticks;
    logic                         timer_on;
    logic                         own_bit;
    logic                         applied_bit;
    logic                         out_q;
    logic [cpbd_pkg::STEP_W-1:0]  steps_left;
    logic [cpbd_pkg::STEP_W-1:0]  gap_left;
    logic                         step_high;
    logic                         dir_q;

    node_view_t due_views[$];
    node_view_t want;

    task report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    // gap over: next pulse, or the move is done
    task end_gap();
        if (steps_left != '0)
            step_high = 1'b1;
        else
            applied_bit = own_bit;
    endtask

    task advance_node(input logic kind, input logic level);
        logic [cpbd_pkg::TICK_W:0] next_ticks;
        node_view_t                v;
        if (kind == cpbd_pkg::OP_EDGE)
        begin
            case (phase_q)
                cpbd_pkg::PH_IDLE:
                begin
                    if (!level)
                    begin
                        ticks    = '0;
                        timer_on = 1'b1;
                        phase_q  = cpbd_pkg::PH_START;
                    end
                end
                cpbd_pkg::PH_START:
                begin
                    if (ticks > {1'b0, start_min})
                    begin
                        ticks   = '0;
                        out_q   = 1'b0;
                        phase_q = cpbd_pkg::PH_BIT;
                    end
                    else
                        phase_q = cpbd_pkg::PH_ABORT;
                end
                cpbd_pkg::PH_BIT:
                begin
                    own_bit = (ticks != 5'd1);
                    phase_q = cpbd_pkg::PH_FWD;
                end
                cpbd_pkg::PH_FWD:
                begin
                    out_q = level;
                    ticks = '0;
                end
                cpbd_pkg::PH_ABORT:
                begin
                    timer_on = 1'b0;
                    out_q    = 1'b1;
                    phase_q  = cpbd_pkg::PH_IDLE;
                end
                default:
                    phase_q = cpbd_pkg::PH_IDLE;
            endcase
        end
        else
        begin
            if (timer_on)
            begin
                next_ticks = {1'b0, ticks} + 1'b1;
                if (next_ticks > {1'b0, frame_timeout})
                begin
                    phase_q  = cpbd_pkg::PH_IDLE;
                    ticks    = '0;
                    timer_on = 1'b0;
                    out_q    = 1'b1;
                end
                else
                    ticks = next_ticks[cpbd_pkg::TICK_W-1:0];
            end
            // stepper runs on every tick
            if (step_high)
            begin
                step_high  = 1'b0;
                steps_left = steps_left - 1'b1;
                gap_left   = step_gap;
                if (gap_left == '0)
                    end_gap();
            end
            else if (gap_left != '0)
            begin
                gap_left = gap_left - 1'b1;
                if (gap_left == '0)
                    end_gap();
            end
        end
        // new move once idle with a changed bit
        if (!step_high && gap_left == '0 && phase_q == cpbd_pkg::PH_IDLE &&
            own_bit != applied_bit)
        begin
            dir_q      = ~own_bit;
            steps_left = step_count;
            if (steps_left != '0)
                step_high = 1'b1;
            else
                applied_bit = own_bit;
        end
        v.out_level    = out_q;
        v.bit_value    = own_bit;
        v.motor_enable = step_high | (gap_left != '0);
        v.motor_dir    = dir_q;
        v.step_pulse   = step_high;
        v.phase        = phase_q;
        due_views.push_back(v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min     = cpbd_pkg::START_MIN_RST;
            frame_timeout = cpbd_pkg::FRAME_TIMEOUT_RST;
            step_count    = cpbd_pkg::STEP_COUNT_RST;
            step_gap      = cpbd_pkg::STEP_GAP_RST;
            phase_q       = cpbd_pkg::PH_IDLE;
            ticks         = '0;
            timer_on      = 1'b0;
            own_bit       = 1'b0;
            applied_bit   = 1'b0;
            out_q         = 1'b0;
            steps_left    = '0;
            gap_left      = '0;
            step_high     = 1'b0;
            dir_q         = 1'b0;
            mismatches    = 0;
            due_views.delete();
            outstanding <= 0;
        end
        else
        begin
            if (evt.valid && evt.ready)
                advance_node(evt.op, evt.line_level);
            if (cfg_we)
            begin
                case (cfg_index)
                    cpbd_pkg::CFG_START_MIN:
                        start_min = cfg_data[cpbd_pkg::START_W-1:0];
                    cpbd_pkg::CFG_FRAME_TIMEOUT:
                        frame_timeout = cfg_data[cpbd_pkg::TICK_W-1:0];
                    cpbd_pkg::CFG_STEP_COUNT:
                        step_count = cfg_data[cpbd_pkg::STEP_W-1:0];
                    cpbd_pkg::CFG_STEP_GAP:
                        step_gap = cfg_data[cpbd_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                if (due_views.size() == 0)
                    report_mismatch("unexpected result", res.phase, 0);
                else
                begin
                    want = due_views.pop_front();
                    if (res.out_level !== want.out_level)
                        report_mismatch("out_level", res.out_level, want.out_level);
                    if (res.bit_value !== want.bit_value)
                        report_mismatch("bit_value", res.bit_value, want.bit_value);
                    if (res.motor_enable !== want.motor_enable)
                        report_mismatch("motor_enable", res.motor_enable, want.motor_enable);
                    if (res.motor_dir !== want.motor_dir)
                        report_mismatch("motor_dir", res.motor_dir, want.motor_dir);
                    if (res.step_pulse !== want.step_pulse)
                        report_mismatch("step_pulse", res.step_pulse, want.step_pulse);
                    if (res.phase !== want.phase)
                        report_mismatch("phase", res.phase, want.phase);
                end
            end
            outstanding <= due_views.size();
        end
    end

endmodule

### tb/tb_chained_pulse_bit_decoder_stepper.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_chained_pulse_bit_decoder_stepper: stimulus and verdict for the node
// Drives pulse-width frames, timer ticks and noise through the event channel
// under several register settings, with random idle gaps on the event side and random backpressure on the result side.
// Prediction and comparison live in cpbd_result_checker.
// ============================================================================
module tb_chained_pulse_bit_decoder_stepper;

    localparam int CYCLE_LIMIT = 200000;  // far above a slow correct run
    localparam int HOLD_CYCLES = 60;      // long result-side stall
    localparam int PHASE_ITEMS = 160;     // random events per register set
    localparam int IDLE_PCT    = 22;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [cpbd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cpbd_pkg::CFG_DATA_W-1:0]  cfg_data;

    cpbd_evt_if evt_ch ();
    cpbd_res_if res_ch ();

    int  mismatches;
    int  outstanding;
    int  events_sent = 0;
    int  cycle_count = 0;
    int  hold_ask    = 0;       // bumped to request one long stall
    logic no_idle    = 1'b0;    // both sides run flat out while set

    // stimulus-side copy of the frame timing, used only to shape frames
    int cur_start_min = cpbd_pkg::START_MIN_RST;
    int cur_timeout   = cpbd_pkg::FRAME_TIMEOUT_RST;

    chained_pulse_bit_decoder_stepper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt_ch),
        .res       (res_ch)
    );

    cpbd_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .evt         (evt_ch),
        .res         (res_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: ends a hung run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side. Random stalls, a quiet stretch on request, and one long
    // hold-off per request so the output stage fills and the event channel
    // has to back up.
    initial
    begin
        int hold_seen;
        hold_seen    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // One event transfer. Valid stays high between back-to-back events; it
    // only drops for a random gap or when the sender stops.
    task automatic send_evt(input logic kind, input logic level);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.op         <= kind;
        evt_ch.line_level <= level;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        events_sent++;
    endtask

    // Ticks carry a random, ignored line level.
    task automatic send_ticks(input int count);
        repeat (count) send_evt(cpbd_pkg::OP_TICK, 1'($urandom_range(1)));
    endtask

    // Stop offering and wait until every predicted result has been taken,
    // then wait out the result stage.
    task automatic drain();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input logic [cpbd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Writes all four registers back to back; only called after drain().
    task automatic load_settings(input int start_min, input int timeout,
                                 input int steps, input int gap);
        put_reg(cpbd_pkg::CFG_START_MIN, 8'(start_min));
        put_reg(cpbd_pkg::CFG_FRAME_TIMEOUT, 8'(timeout));
        put_reg(cpbd_pkg::CFG_STEP_COUNT, 8'(steps));
        put_reg(cpbd_pkg::CFG_STEP_GAP, 8'(gap));
        cfg_we        <= 1'b0;
        cur_start_min  = start_min;
        cur_timeout    = timeout;
        @(posedge clk);
    endtask

    // One frame as the upstream node would send it: start pulse, own bit
    // width, a few forwarded edges, then silence until the frame times out.
    // Some start pulses are too short (abort path) and some frames are cut
    // short so the next start lands in the forward phase.
    task automatic send_frame();
        int width;
        send_evt(cpbd_pkg::OP_EDGE, 1'b0);
        if ($urandom_range(7) == 0)
            width = $urandom_range(cur_start_min, 0);
        else
            width = cur_start_min + 1 + $urandom_range(1);
        send_ticks(width);
        send_evt(cpbd_pkg::OP_EDGE, 1'b1);
        // one tick decodes 0; anything else decodes 1
        width = $urandom_range(1) ? 1 : $urandom_range(3);
        send_ticks(width);
        send_evt(cpbd_pkg::OP_EDGE, 1'b0);
        repeat ($urandom_range(4))
        begin
            send_ticks($urandom_range(3));
            send_evt(cpbd_pkg::OP_EDGE, 1'($urandom_range(1)));
        end
        if ($urandom_range(5) != 0)
            send_ticks(cur_timeout + 1);
    endtask

    // Mostly well-formed frames; some tick runs to let a move advance, and
    // some single random events as noise.
    task automatic play_random(input int count);
        int stop_at;
        stop_at = events_sent + count;
        while (events_sent < stop_at)
        begin
            case ($urandom_range(9))
                0:       send_evt(1'($urandom_range(1)), 1'($urandom_range(1)));
                1:       send_ticks($urandom_range(24, 1));
                default: send_frame();
            endcase
        end
    endtask

    initial
    begin
        int s;
        int t;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        evt_ch.valid      = 1'b0;
        evt_ch.op         = cpbd_pkg::OP_EDGE;
        evt_ch.line_level = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, register reset values (start 3, timeout 15) ----
        send_evt(cpbd_pkg::OP_TICK, 1'b1);   // tick with the frame timer off
        send_evt(cpbd_pkg::OP_EDGE, 1'b1);   // rising edge in idle is ignored
        send_evt(cpbd_pkg::OP_EDGE, 1'b0);   // start pulse begins
        send_ticks(1);
        send_evt(cpbd_pkg::OP_EDGE, 1'b1);   // too short: abort
        send_evt(cpbd_pkg::OP_EDGE, 1'b0);   // abort returns to idle, line high
        send_evt(cpbd_pkg::OP_EDGE, 1'b0);   // new start pulse
        send_ticks(4);                       // one past the start threshold
        send_evt(cpbd_pkg::OP_EDGE, 1'b1);   // start accepted, downstream low
        send_ticks(1);
        send_evt(cpbd_pkg::OP_EDGE, 1'b0);   // one-tick width: own bit 0
        send_evt(cpbd_pkg::OP_EDGE, 1'b1);   // forwarded edges
        send_ticks(1);
        send_evt(cpbd_pkg::OP_EDGE, 1'b0);
        send_ticks(16);                      // count passes the timeout here

        // ---- random at reset values, with one long result stall ----
        hold_ask <= hold_ask + 1;
        play_random(PHASE_ITEMS);

        // ---- register sets: lows (zero-step move), highs, zero gap, mixed ----
        for (int set_i = 0; set_i < 8; set_i++)
        begin
            drain();
            case (set_i)
                0: load_settings(0, 1, 0, 1);
                1: load_settings(15, 30, 255, 255);
                2: load_settings(2, 12, 3, 0);      // pulses merge into one level
                3: load_settings(1, 8, 2, 1);
                4, 5:
                begin
                    s = $urandom_range(5);
                    t = $urandom_range(30, s + 3);
                    load_settings(s, t, $urandom_range(8, 1), $urandom_range(6, 1));
                end
                6: load_settings(4, 20, 5, 3);
                default: load_settings(cpbd_pkg::START_MIN_RST,
                                       cpbd_pkg::FRAME_TIMEOUT_RST,
                                       cpbd_pkg::STEP_COUNT_RST,
                                       cpbd_pkg::STEP_GAP_RST);
            endcase
            // one set runs without any idling, another gets a second stall
            no_idle <= (set_i == 3);
            if (set_i == 6)
                hold_ask <= hold_ask + 1;
            play_random(PHASE_ITEMS);
        end
        no_idle <= 1'b0;

        drain();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/cpbd_pkg.sv
rtl/cpbd_evt_if.sv
rtl/cpbd_res_if.sv
rtl/chained_pulse_bit_decoder_stepper.sv
tb/cpbd_result_checker.sv
tb/tb_chained_pulse_bit_decoder_stepper.sv
